[hw/rtl/dcf_pkg.sv]
`default_nettype none

package dcf_pkg;

    localparam int NUM_CH  = 3;
    localparam int CH_W    = 8;
    localparam int COLOR_W = NUM_CH * CH_W;
    localparam int PROD_W  = 18;
    localparam int NUM_W   = 16;

    localparam logic [CH_W-1:0] CH_FULL  = 8'hFF;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h00;
    localparam logic [CH_W-1:0] CH_ROUND = 8'd127;

    typedef enum logic [1:0] {
        REG_BACKGROUND = 2'd0,
        REG_FOREGROUND = 2'd1,
        REG_FORMAT     = 2'd2,
        REG_REMOVE     = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [COLOR_W-1:0] bg;
        logic [COLOR_W-1:0] fg;
        logic               fmt;
        logic               rem;
    } cfg_t;

    // Channel 0 is blue, 1 green, 2 red.
    typedef struct packed {
        logic [NUM_CH-1:0][CH_W-1:0] ch;
        logic [CH_W-1:0]             alpha;
        logic                        last;
    } pix_t;

    typedef struct packed {
        logic [NUM_CH-1:0][PROD_W-1:0] prod;
        logic [CH_W-1:0]               alpha;
        logic                          last;
    } prod_t;

    typedef struct packed {
        logic [NUM_CH-1:0][CH_W-1:0]  m;
        logic [NUM_CH-1:0][NUM_W-1:0] num;
        logic [CH_W-1:0]              alpha;
        logic                         last;
    } mix_t;

    // Blue sits in the high byte of a packed color, red in the low byte.
    function automatic logic [CH_W-1:0] comp(input logic [COLOR_W-1:0] color,
                                             input int unsigned ch);
        return color[(NUM_CH - 1 - ch) * CH_W +: CH_W];
    endfunction

endpackage

`default_nettype wire

[hw/rtl/dcf_mul_stage.sv]
`default_nettype none

module dcf_mul_stage (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire dcf_pkg::cfg_t cfg,
    input  wire logic          advance,
    input  wire logic          in_valid,
    input  wire dcf_pkg::pix_t in_data,
    output logic               out_valid,
    output dcf_pkg::prod_t     out_data
);

    logic           valid_reg;
    dcf_pkg::prod_t data_reg;
    dcf_pkg::prod_t data_next;

    // Product of the signed color span and the inverted channel value.
    always_comb
    begin
        logic signed [8:0]                 k;
        logic [dcf_pkg::CH_W-1:0]          d;
        logic signed [dcf_pkg::PROD_W-1:0] ke;
        logic signed [dcf_pkg::PROD_W-1:0] de;
        data_next       = '0;
        data_next.alpha = in_data.alpha;
        data_next.last  = in_data.last;
        for (int unsigned i = 0; i < dcf_pkg::NUM_CH; i++)
        begin
            k  = $signed({1'b0, dcf_pkg::comp(cfg.fg, i)})
               - $signed({1'b0, dcf_pkg::comp(cfg.bg, i)});
            d  = dcf_pkg::CH_FULL - in_data.ch[i];
            ke = {{(dcf_pkg::PROD_W - 9){k[8]}}, k};
            de = $signed({{(dcf_pkg::PROD_W - dcf_pkg::CH_W){1'b0}}, d});
            data_next.prod[i] = ke * de;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

[hw/rtl/dcf_mix_stage.sv]
`default_nettype none

module dcf_mix_stage (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire dcf_pkg::cfg_t  cfg,
    input  wire logic           advance,
    input  wire logic           in_valid,
    input  wire dcf_pkg::prod_t in_data,
    output logic                out_valid,
    output dcf_pkg::mix_t       out_data
);

    logic          valid_reg;
    dcf_pkg::mix_t data_reg;
    dcf_pkg::mix_t data_next;

    // Finish the ramp value, then form the blend numerator m*a + (255-a)*bg + 127.
    always_comb
    begin
        logic [9:0]                q;
        logic [10:0]               m_wide;
        logic [dcf_pkg::CH_W-1:0]  m;
        logic [dcf_pkg::NUM_W-1:0] p_fg;
        logic [dcf_pkg::NUM_W-1:0] p_bg;
        data_next       = '0;
        data_next.alpha = in_data.alpha;
        data_next.last  = in_data.last;
        for (int unsigned i = 0; i < dcf_pkg::NUM_CH; i++)
        begin
            // Dropping the low byte of the signed product is a floor shift.
            q      = in_data.prod[i][dcf_pkg::PROD_W-1:8];
            m_wide = {3'b000, dcf_pkg::comp(cfg.fg, i)} - {q[9], q};
            m      = m_wide[dcf_pkg::CH_W-1:0];
            p_fg   = {8'h00, m} * {8'h00, in_data.alpha};
            p_bg   = {8'h00, dcf_pkg::CH_FULL - in_data.alpha}
                   * {8'h00, dcf_pkg::comp(cfg.bg, i)};
            data_next.m[i]   = m;
            data_next.num[i] = p_fg + p_bg + {8'h00, dcf_pkg::CH_ROUND};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

[hw/rtl/dcf_div_stage.sv]
`default_nettype none

module dcf_div_stage (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire dcf_pkg::cfg_t cfg,
    input  wire logic          advance,
    input  wire logic          in_valid,
    input  wire dcf_pkg::mix_t in_data,
    output logic               out_valid,
    output dcf_pkg::pix_t      out_data
);

    logic          valid_reg;
    dcf_pkg::pix_t data_reg;
    dcf_pkg::pix_t data_next;
    logic          flatten;

    assign flatten = cfg.fmt & cfg.rem;

    // x/255 starts from x*257/65536, which is at most one short; the remainder
    // check adds that one back.
    always_comb
    begin
        logic [dcf_pkg::NUM_W-1:0] x;
        logic [23:0]               x257;
        logic [dcf_pkg::CH_W-1:0]  q0;
        logic [16:0]               q255;
        logic [16:0]               r;
        logic [dcf_pkg::CH_W-1:0]  blended;
        data_next      = '0;
        data_next.last = in_data.last;
        for (int unsigned i = 0; i < dcf_pkg::NUM_CH; i++)
        begin
            x       = in_data.num[i];
            x257    = {x, 8'h00} + {8'h00, x};
            q0      = x257[23:16];
            q255    = {1'b0, q0, 8'h00} - {9'h000, q0};
            r       = {1'b0, x} - q255;
            blended = (r >= 17'd255) ? q0 + 8'd1 : q0;
            if (!flatten || in_data.alpha == dcf_pkg::CH_FULL)
            begin
                data_next.ch[i] = in_data.m[i];
            end
            else if (in_data.alpha == dcf_pkg::CH_ZERO)
            begin
                data_next.ch[i] = dcf_pkg::comp(cfg.bg, i);
            end
            else
            begin
                data_next.ch[i] = blended;
            end
        end
        data_next.alpha = flatten ? dcf_pkg::CH_FULL : in_data.alpha;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

[hw/rtl/duotone_colorize_flatten.sv]
// Duotone colorizer with alpha flattening. Each BGR(A) pixel is mapped onto a
// ramp between the background and foreground colors and, in 32-bit mode with
// alpha removal on, blended over the background with the output alpha forced
// to 255. The block takes one pixel per clock while the output is not stalled
// and passes each result through three registered stages: a multiply stage,
// a blend-product stage and a divide-by-255 and select stage, each with its
// own valid bit, so a stall on the output only holds the stages that are
// full. Configuration is written through cfg_wen/cfg_index/cfg_data and
// must only change while no pixel is in flight.
`default_nettype none

module duotone_colorize_flatten (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wen,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [23:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // in_blue, in_green, in_red, in_alpha
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // out_blue, out_green, out_red, out_alpha
    output logic             m_tlast
);

    dcf_pkg::cfg_t  cfg_reg;
    dcf_pkg::pix_t  in_pix;
    dcf_pkg::prod_t s1_data;
    dcf_pkg::mix_t  s2_data;
    dcf_pkg::pix_t  s3_data;
    logic           s1_valid;
    logic           s2_valid;
    logic           s3_valid;
    logic           ready1;
    logic           ready2;
    logic           ready3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bg  <= 24'h000000;
            cfg_reg.fg  <= 24'hFFFFFF;
            cfg_reg.fmt <= 1'b1;
            cfg_reg.rem <= 1'b1;
        end
        else if (cfg_wen)
        begin
            unique case (dcf_pkg::cfg_idx_t'(cfg_index))
                dcf_pkg::REG_BACKGROUND: cfg_reg.bg  <= cfg_data;
                dcf_pkg::REG_FOREGROUND: cfg_reg.fg  <= cfg_data;
                dcf_pkg::REG_FORMAT:     cfg_reg.fmt <= cfg_data[0];
                dcf_pkg::REG_REMOVE:     cfg_reg.rem <= cfg_data[0];
                default:                 cfg_reg     <= cfg_reg;
            endcase
        end
    end

    // A stage moves on when it is empty or the stage after it moves on.
    assign ready3   = !s3_valid || m_tready;
    assign ready2   = !s2_valid || ready3;
    assign ready1   = !s1_valid || ready2;
    assign s_tready = ready1;

    assign in_pix.ch    = s_tdata[23:0];
    assign in_pix.alpha = s_tdata[31:24];
    assign in_pix.last  = s_tlast;

    dcf_mul_stage u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .advance   (ready1),
        .in_valid  (s_tvalid),
        .in_data   (in_pix),
        .out_valid (s1_valid),
        .out_data  (s1_data)
    );

    dcf_mix_stage u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .advance   (ready2),
        .in_valid  (s1_valid),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_data  (s2_data)
    );

    dcf_div_stage u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .advance   (ready3),
        .in_valid  (s2_valid),
        .in_data   (s2_data),
        .out_valid (s3_valid),
        .out_data  (s3_data)
    );

    assign m_tvalid = s3_valid;
    assign m_tdata  = {s3_data.alpha, s3_data.ch};
    assign m_tlast  = s3_data.last;

endmodule

`default_nettype wire

[hw/rtl/dcf_checker.sv]
`default_nettype none

module dcf_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        m_tlast
);

    // A result waiting on the output keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output changed while stalled");

    // With the output draining, the pipeline never pushes back on the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while output is ready");

    // A transfer in reaches the output through the multiply, mix and divide stages when nothing stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) ##1 m_tready ##1 m_tready |=> m_tvalid)
        else $error("result did not arrive after three cycles");

    assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("output valid during reset");

endmodule

bind duotone_colorize_flatten dcf_checker u_dcf_checker (.*);

`default_nettype wire
